// ===== rtl/kscd_pkg.sv =====
// Shared types, constants and character tables for the keyboard scancode decoder.
`default_nettype none

package kscd_pkg;

	localparam int QDEPTH    = 32;
	localparam int QAW       = $clog2(QDEPTH);
	localparam int QCW       = $clog2(QDEPTH + 1);
	localparam int QBANK     = QDEPTH / 2;
	localparam int RES_DEPTH = 4;
	localparam int RAW       = $clog2(RES_DEPTH);
	localparam int RCW       = $clog2(RES_DEPTH + 1);

	localparam logic [7:0] SC_BKSP        = 8'h0E;
	localparam logic [7:0] SC_TAB         = 8'h0F;
	localparam logic [7:0] SC_ENTER       = 8'h1C;
	localparam logic [7:0] SC_LSHIFT      = 8'h2A;
	localparam logic [7:0] SC_RSHIFT      = 8'h36;
	localparam logic [7:0] SC_CAPS        = 8'h3A;
	localparam logic [7:0] SC_F1          = 8'h3B;
	localparam logic [7:0] SC_NUM         = 8'h45;
	localparam logic [7:0] SC_SCROLL      = 8'h46;
	localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
	localparam logic [7:0] SC_ACK         = 8'hFA;
	localparam logic [7:0] SC_RESEND      = 8'hFE;

	localparam logic [7:0] KB_SET_LEDS    = 8'hED;
	localparam logic [7:0] KB_NONE        = 8'hFF;

	localparam logic [2:0] LED_CAPS       = 3'b100;
	localparam logic [2:0] LED_NUM        = 3'b010;
	localparam logic [2:0] LED_SCROLL     = 3'b001;

	localparam logic [2:0] EV_CHAR        = 3'd0;
	localparam logic [2:0] EV_BKSP        = 3'd1;
	localparam logic [2:0] EV_ENTER       = 3'd2;
	localparam logic [2:0] EV_FOCUS       = 3'd3;
	localparam logic [2:0] EV_BREAK       = 3'd4;
	localparam logic [2:0] EV_CMD         = 3'd5;

	typedef logic [QAW-1:0] qaddr_t;
	typedef logic [QCW-1:0] qcount_t;

	typedef struct packed {
		logic [7:0] scancode;
		logic       app_running;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [7:0] event_value;
		logic       target;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic       en;
		qaddr_t     addr;
		logic [7:0] data;
	} qwr_t;

	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  e0;
		out_item_t  e1;
	} res_push_t;

	function automatic logic [7:0] kscd_char(input logic [6:0] code, input logic sh);
		logic [7:0] c;
		c = 8'h00;
		case (code)
			7'h02: c = sh ? 8'h21 : 8'h31;
			7'h03: c = sh ? 8'h22 : 8'h32;
			7'h04: c = sh ? 8'h23 : 8'h33;
			7'h05: c = sh ? 8'h24 : 8'h34;
			7'h06: c = sh ? 8'h25 : 8'h35;
			7'h07: c = sh ? 8'h26 : 8'h36;
			7'h08: c = sh ? 8'h27 : 8'h37;
			7'h09: c = sh ? 8'h28 : 8'h38;
			7'h0A: c = sh ? 8'h29 : 8'h39;
			7'h0B: c = sh ? 8'h7E : 8'h30;
			7'h0C: c = sh ? 8'h3D : 8'h2D;
			7'h0D: c = sh ? 8'h7E : 8'h5E;
			7'h10: c = 8'h51;
			7'h11: c = 8'h57;
			7'h12: c = 8'h45;
			7'h13: c = 8'h52;
			7'h14: c = 8'h54;
			7'h15: c = 8'h59;
			7'h16: c = 8'h55;
			7'h17: c = 8'h49;
			7'h18: c = 8'h4F;
			7'h19: c = 8'h50;
			7'h1A: c = sh ? 8'h60 : 8'h40;
			7'h1B: c = sh ? 8'h7B : 8'h5B;
			7'h1E: c = 8'h41;
			7'h1F: c = 8'h53;
			7'h20: c = 8'h44;
			7'h21: c = 8'h46;
			7'h22: c = 8'h47;
			7'h23: c = 8'h48;
			7'h24: c = 8'h4A;
			7'h25: c = 8'h4B;
			7'h26: c = 8'h4C;
			7'h27: c = sh ? 8'h2B : 8'h3B;
			7'h28: c = sh ? 8'h2A : 8'h3A;
			7'h2B: c = sh ? 8'h7D : 8'h5D;
			7'h2C: c = 8'h5A;
			7'h2D: c = 8'h58;
			7'h2E: c = 8'h43;
			7'h2F: c = 8'h56;
			7'h30: c = 8'h42;
			7'h31: c = 8'h4E;
			7'h32: c = 8'h4D;
			7'h33: c = sh ? 8'h3C : 8'h2C;
			7'h34: c = sh ? 8'h3E : 8'h2E;
			7'h35: c = sh ? 8'h3F : 8'h2F;
			7'h37: c = 8'h2A;
			7'h39: c = 8'h20;
			7'h47: c = 8'h37;
			7'h48: c = 8'h38;
			7'h49: c = 8'h39;
			7'h4A: c = 8'h2D;
			7'h4B: c = 8'h34;
			7'h4C: c = 8'h35;
			7'h4D: c = 8'h36;
			7'h4E: c = 8'h2B;
			7'h4F: c = 8'h31;
			7'h50: c = 8'h32;
			7'h51: c = 8'h33;
			7'h52: c = 8'h30;
			7'h53: c = 8'h2E;
			7'h73: c = sh ? 8'h5F : 8'h5C;
			7'h7D: c = sh ? 8'h7C : 8'h5C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/keyboard_scancode_decoder_unit.sv =====
// Top level of the set-1 scancode decoder with LED command queue and result buffer.
//
//  Port group   Dir   Handshake            Payload
//  in_*         in    in_valid / in_stall  in_item_t: scancode, app_running
//  out_*        out   out_valid / out_stall out_item_t: kind, value, target, last
//  cfg_*        in    cfg_valid / cfg_ready 3-bit initial_leds
//
//  One scancode per cycle while in_stall is low; results pass through the stage-1 registers and then the result buffer.
//  The command byte comes out of the queue RAM in the cycle after its read.
//  Reset: no clearing pass; the first two queue entries read from flops until rewritten.
//  in_stall rises only when the four-entry result buffer could overflow.
//  out_stall holds results in the buffer; configuration is always ready.
`default_nettype none

module keyboard_scancode_decoder_unit
	import kscd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_data
);

	logic [1:0] shift_q;
	logic [2:0] leds_q;
	logic [2:0] qled_q;
	logic       focus_q;
	logic       ack_q;
	logic       started_q;
	logic [7:0] outst_q;
	qaddr_t     head_q;
	qcount_t    count_q;
	logic [1:0] pre_q;

	logic       v_s1;
	logic       r0v_s1;
	out_item_t  r0_s1;
	logic       send_s1;
	logic       tgt_s1;
	logic       mem_s1;
	logic [7:0] byte_s1;

	logic       in_accept;
	logic [7:0] sc;
	logic [7:0] ch;
	logic [7:0] ch_fix;
	logic       r0v;
	out_item_t  r0;
	logic [1:0] shift_n;
	logic [2:0] leds_n;
	logic       focus_n;
	logic       ack_n;
	logic       lock;
	logic [7:0] outst_eff;
	qaddr_t     tail;
	qwr_t       wr_a, wr_b;
	qcount_t    count_after;
	logic       send;
	logic       fwd;
	logic [7:0] fwd_byte;
	logic [7:0] mem_rdata;
	logic [7:0] sent_s1;
	logic [1:0] s1_n;
	res_push_t  push;
	logic [RCW-1:0] level;

	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign sc        = in_data.scancode;
	assign outst_eff = (v_s1 && send_s1) ? sent_s1 : outst_q;

	always_comb begin
		ch = sc[7] ? 8'h00 : kscd_char(sc[6:0], shift_q != 2'b00);
		ch_fix = ch;
		if (ch >= 8'h41 && ch <= 8'h5A && (leds_q[2] == (shift_q != 2'b00))) begin
			ch_fix = ch + 8'h20;
		end
	end

	always_comb begin
		r0v     = 1'b0;
		r0      = '0;
		shift_n = shift_q;
		leds_n  = leds_q;
		focus_n = focus_q;
		ack_n   = ack_q;
		lock    = 1'b0;
		if (ch_fix != 8'h00) begin
			r0v            = 1'b1;
			r0.event_kind  = EV_CHAR;
			r0.event_value = ch_fix;
		end else begin
			unique case (sc)
				SC_BKSP: begin
					r0v           = 1'b1;
					r0.event_kind = EV_BKSP;
				end
				SC_ENTER: begin
					r0v           = focus_q;
					r0.event_kind = EV_ENTER;
				end
				SC_TAB: begin
					focus_n       = !focus_q;
					r0v           = 1'b1;
					r0.event_kind = EV_FOCUS;
				end
				SC_LSHIFT:     shift_n = shift_q | 2'b01;
				SC_RSHIFT:     shift_n = shift_q | 2'b10;
				SC_LSHIFT_BRK: shift_n = shift_q & 2'b10;
				SC_RSHIFT_BRK: shift_n = shift_q & 2'b01;
				SC_CAPS: begin
					leds_n = leds_q ^ LED_CAPS;
					lock   = 1'b1;
				end
				SC_NUM: begin
					leds_n = leds_q ^ LED_NUM;
					lock   = 1'b1;
				end
				SC_SCROLL: begin
					leds_n = leds_q ^ LED_SCROLL;
					lock   = 1'b1;
				end
				SC_F1: begin
					r0v           = (shift_q != 2'b00) && in_data.app_running;
					r0.event_kind = EV_BREAK;
				end
				SC_ACK: ack_n = 1'b0;
				SC_RESEND: begin
					r0v            = 1'b1;
					r0.event_kind  = EV_CMD;
					r0.event_value = ack_q ? outst_eff : KB_NONE;
				end
				default: ;
			endcase
		end
		r0.target = focus_n;
		r0.last   = 1'b0;
	end

	always_comb begin
		tail        = head_q + count_q[QAW-1:0];
		wr_a.en     = in_accept && lock && (count_q < qcount_t'(QDEPTH));
		wr_a.addr   = tail;
		wr_a.data   = KB_SET_LEDS;
		wr_b.en     = in_accept && lock && (count_q < qcount_t'(QDEPTH - 1));
		wr_b.addr   = tail + 1'b1;
		wr_b.data   = {5'd0, leds_n};
		count_after = count_q + qcount_t'(wr_a.en) + qcount_t'(wr_b.en);
		send        = !ack_n && (count_after != '0);
		fwd         = 1'b1;
		fwd_byte    = KB_SET_LEDS;
		if (wr_a.en && wr_a.addr == head_q) begin
			fwd_byte = KB_SET_LEDS;
		end else if (wr_b.en && wr_b.addr == head_q) begin
			fwd_byte = wr_b.data;
		end else if (head_q == qaddr_t'(0) && pre_q[0]) begin
			fwd_byte = KB_SET_LEDS;
		end else if (head_q == qaddr_t'(1) && pre_q[1]) begin
			fwd_byte = {5'd0, qled_q};
		end else begin
			fwd = 1'b0;
		end
	end

	kscd_qmem u_qmem (
		.clk     (clk),
		.wr_a    (wr_a),
		.wr_b    (wr_b),
		.rd_en   (in_accept && send),
		.rd_addr (head_q),
		.rd_data (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= 2'b00;
			leds_q    <= 3'd0;
			qled_q    <= 3'd0;
			focus_q   <= 1'b0;
			ack_q     <= 1'b0;
			started_q <= 1'b0;
			outst_q   <= 8'h00;
			head_q    <= '0;
			count_q   <= qcount_t'(2);
			pre_q     <= 2'b11;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= in_accept;
			if (in_accept) begin
				shift_q   <= shift_n;
				leds_q    <= leds_n;
				focus_q   <= focus_n;
				ack_q     <= ack_n || send;
				started_q <= 1'b1;
				head_q    <= head_q + qaddr_t'(send);
				count_q   <= count_after - qcount_t'(send);
				if ((wr_a.en && wr_a.addr == qaddr_t'(0)) ||
				    (wr_b.en && wr_b.addr == qaddr_t'(0))) begin
					pre_q[0] <= 1'b0;
				end
				if ((wr_a.en && wr_a.addr == qaddr_t'(1)) ||
				    (wr_b.en && wr_b.addr == qaddr_t'(1))) begin
					pre_q[1] <= 1'b0;
				end
			end else if (cfg_valid && cfg_ready) begin
				leds_q <= cfg_data;
				if (!started_q) begin
					qled_q <= cfg_data;
				end
			end
			if (v_s1 && send_s1) begin
				outst_q <= sent_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			r0v_s1  <= r0v;
			r0_s1   <= r0;
			send_s1 <= send;
			tgt_s1  <= focus_n;
			mem_s1  <= !fwd;
			byte_s1 <= fwd_byte;
		end
	end

	assign sent_s1 = mem_s1 ? mem_rdata : byte_s1;
	assign s1_n    = v_s1 ? (2'(r0v_s1) + 2'(send_s1)) : 2'd0;

	always_comb begin
		out_item_t cmd;
		cmd.event_kind  = EV_CMD;
		cmd.event_value = sent_s1;
		cmd.target      = tgt_s1;
		cmd.last        = 1'b1;
		push.cnt = s1_n;
		push.e1  = cmd;
		if (r0v_s1) begin
			push.e0      = r0_s1;
			push.e0.last = !send_s1;
		end else begin
			push.e0 = cmd;
		end
	end

	kscd_res_fifo u_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.level     (level)
	);

	assign in_stall = ({1'b0, level} + (RCW+1)'(s1_n) + (RCW+1)'(2)) >
	                  (RCW+1)'(RES_DEPTH);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= qcount_t'(QDEPTH))
		else $error("command queue count beyond depth");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ({1'b0, level} + (RCW+1)'(s1_n)) <= (RCW+1)'(RES_DEPTH))
		else $error("result buffer overflow");

	a_send_waits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && send_s1 |-> ack_q)
		else $error("command byte sent without awaiting acknowledge");

	a_send_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && count_q == '0 && !wr_a.en |-> !send)
		else $error("command send from empty queue");

endmodule

`default_nettype wire

// ===== rtl/kscd_qmem.sv =====
// Command queue storage: two single-port-write banks split on the low address bit.
`default_nettype none

module kscd_qmem
	import kscd_pkg::*;
(
	input  wire logic       clk,
	input  wire qwr_t       wr_a,
	input  wire qwr_t       wr_b,
	input  wire logic       rd_en,
	input  wire qaddr_t     rd_addr,
	output logic [7:0]      rd_data
);

	logic [7:0] bank0 [QBANK];
	logic [7:0] bank1 [QBANK];

	logic           we0, we1;
	logic [QAW-2:0] wa0, wa1;
	logic [7:0]     wd0, wd1;
	logic [7:0]     rd0_q, rd1_q;
	logic           sel_q;

	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		wa0 = wr_a.addr[QAW-1:1];
		wa1 = wr_a.addr[QAW-1:1];
		wd0 = wr_a.data;
		wd1 = wr_a.data;
		if (wr_a.en && !wr_a.addr[0]) begin
			we0 = 1'b1;
		end else if (wr_b.en && !wr_b.addr[0]) begin
			we0 = 1'b1;
			wa0 = wr_b.addr[QAW-1:1];
			wd0 = wr_b.data;
		end
		if (wr_a.en && wr_a.addr[0]) begin
			we1 = 1'b1;
		end else if (wr_b.en && wr_b.addr[0]) begin
			we1 = 1'b1;
			wa1 = wr_b.addr[QAW-1:1];
			wd1 = wr_b.data;
		end
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			bank0[wa0] <= wd0;
		end
		if (we1) begin
			bank1[wa1] <= wd1;
		end
		if (rd_en) begin
			rd0_q <= bank0[rd_addr[QAW-1:1]];
			rd1_q <= bank1[rd_addr[QAW-1:1]];
			sel_q <= rd_addr[0];
		end
	end

	assign rd_data = sel_q ? rd1_q : rd0_q;

endmodule

`default_nettype wire

// ===== rtl/kscd_res_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one per request.
`default_nettype none

module kscd_res_fifo
	import kscd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire res_push_t push,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data,
	output logic [RCW-1:0] level
);

	out_item_t          slot [RES_DEPTH];
	logic [RAW-1:0]     wp_q, rp_q;
	logic [RCW-1:0]     level_q;
	logic               pop;
	logic [RAW-1:0]     wp1;

	assign pop       = out_valid && !out_stall;
	assign wp1       = wp_q + 1'b1;
	assign out_valid = (level_q != '0);
	assign out_data  = slot[rp_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			slot[wp_q] <= push.e0;
		end
		if (push.cnt == 2'd2) begin
			slot[wp1] <= push.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			level_q <= '0;
		end else begin
			wp_q    <= wp_q + RAW'(push.cnt);
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			level_q <= level_q + RCW'(push.cnt) - RCW'(pop);
		end
	end

endmodule

`default_nettype wire
